@@ rtl/clat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clat_pkg
// Shared types and codes for the banked client address table.
// ----------------------------------------------------------------------------
package clat_pkg;

   localparam int ADDR_W = 32;
   localparam int STAMP_W = 32;
   localparam int OCC_W = 5;

   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_INSERT = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0]  client_addr;
      logic [STAMP_W-1:0] now;
   } req_word_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] evicted_addr;
      logic [OCC_W-1:0]  occupancy;
   } rsp_word_type;

endpackage

@@ rtl/clat_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clat_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface clat_req_if;
   import clat_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

@@ rtl/clat_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clat_rsp_if
// Response channel: valid/ready handshake carrying one response word.
// ----------------------------------------------------------------------------
interface clat_rsp_if;
   import clat_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

@@ rtl/client_address_table_lru.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_address_table_lru
// Two-bank client address table with oldest-stamp replacement.
// ----------------------------------------------------------------------------
// After reset the block sweeps the key and stamp memories to zero, one entry
// per cycle, and takes no request until that is done. Each request then
// walks the slots of its bank (TABLE_ENTRIES/2 of them) through the single
// read port of the memories, one slot per cycle, with one comparator pair
// checking the key and tracking the oldest stamp. Read data comes from the
// registered read port. A finish state then writes back an insert and forms
// the response word, which a response state offers until it is taken. The
// next request is taken in the cycle after the response word has left. One
// request is in flight at a time.
// ----------------------------------------------------------------------------
module client_address_table_lru #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic       clock,
   input  logic       reset,
   clat_req_if.sink   req,
   clat_rsp_if.source rsp
);
   import clat_pkg::*;

   localparam int BANK_SLOTS = TABLE_ENTRIES / 2;
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(BANK_SLOTS + 1);
   localparam int FW = $clog2(TABLE_ENTRIES + 1);

   localparam logic [AW-1:0] BANK1_BASE = AW'(BANK_SLOTS);
   localparam logic [AW-1:0] LAST_ENTRY = AW'(TABLE_ENTRIES - 1);
   localparam logic [CW-1:0] SCAN_END = CW'(BANK_SLOTS);
   localparam logic [FW-1:0] FILL_MAX = FW'(TABLE_ENTRIES);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   // storage
   logic [ADDR_W-1:0]  key_mem   [TABLE_ENTRIES];
   logic [STAMP_W-1:0] stamp_mem [TABLE_ENTRIES];

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               rvalid_ff, rvalid_in;
   logic [AW-1:0]      rslot_ff, rslot_in;
   logic               first_ff, first_in;
   logic               hit_ff, hit_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic [AW-1:0]      best_slot_ff, best_slot_in;
   logic [ADDR_W-1:0]  best_key_ff, best_key_in;
   logic [FW-1:0]      fill_ff, fill_in;
   req_word_type       cur_ff, cur_in;
   rsp_word_type       out_ff, out_in;

   logic [ADDR_W-1:0]  key_q_ff;
   logic [STAMP_W-1:0] stamp_q_ff;

   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [ADDR_W-1:0]  mem_wkey;
   logic [STAMP_W-1:0] mem_wstamp;
   logic [AW-1:0]      mem_ra;
   logic [AW-1:0]      bank_base;

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_RESP);
   assign rsp.word  = out_ff;

   assign bank_base = cur_ff.client_addr[0] ? BANK1_BASE : '0;
   assign mem_ra    = bank_base + AW'(issue_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      issue_in      = issue_ff;
      rvalid_in     = 1'b0;
      rslot_in      = mem_ra;
      first_in      = first_ff;
      hit_in        = hit_ff;
      best_stamp_in = best_stamp_ff;
      best_slot_in  = best_slot_ff;
      best_key_in   = best_key_ff;
      fill_in       = fill_ff;
      cur_in        = cur_ff;
      out_in        = out_ff;
      mem_we        = 1'b0;
      mem_wa        = clr_ff;
      mem_wkey      = '0;
      mem_wstamp    = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ENTRY) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               cur_in   = req.word;
               issue_in = '0;
               first_in = 1'b1;
               hit_in   = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff != SCAN_END) begin
               issue_in  = issue_ff + 1'b1;
               rvalid_in = 1'b1;
            end
            // read data belongs to the address issued in the cycle before
            if (rvalid_ff) begin
               first_in = 1'b0;
               if (key_q_ff == cur_ff.client_addr) begin
                  hit_in = 1'b1;
               end
               // strict compare keeps the lowest slot on equal stamps
               if (first_ff || (stamp_q_ff < best_stamp_ff)) begin
                  best_stamp_in = stamp_q_ff;
                  best_slot_in  = rslot_ff;
                  best_key_in   = key_q_ff;
               end
               if (issue_ff == SCAN_END) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (cur_ff.req_type == REQ_INSERT) begin
               mem_we     = 1'b1;
               mem_wa     = best_slot_ff;
               mem_wkey   = cur_ff.client_addr;
               mem_wstamp = cur_ff.now;
               if (fill_ff != FILL_MAX) begin
                  fill_in = fill_ff + 1'b1;
               end
               out_in.found        = 1'b0;
               out_in.evicted_addr = best_key_ff;
               out_in.occupancy    = OCC_W'(fill_in);
            end else begin
               out_in.found        = hit_ff;
               out_in.evicted_addr = '0;
               out_in.occupancy    = OCC_W'(fill_ff);
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         issue_ff  <= '0;
         rvalid_ff <= 1'b0;
         first_ff  <= 1'b0;
         hit_ff    <= 1'b0;
         fill_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         issue_ff  <= issue_in;
         rvalid_ff <= rvalid_in;
         first_ff  <= first_in;
         hit_ff    <= hit_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      rslot_ff      <= rslot_in;
      best_stamp_ff <= best_stamp_in;
      best_slot_ff  <= best_slot_in;
      best_key_ff   <= best_key_in;
      cur_ff        <= cur_in;
      out_ff        <= out_in;
   end

   // single write port, single registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_wa]   <= mem_wkey;
         stamp_mem[mem_wa] <= mem_wstamp;
      end
      key_q_ff   <= key_mem[mem_ra];
      stamp_q_ff <= stamp_mem[mem_ra];
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-bank client address table. Lookups and
// inserts go in through a valid/ready driver with random gaps. Each accepted
// request word is run through a bench-side copy of the table to predict its
// response word. A monitor with random back-pressure compares each response
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import clat_pkg::*;

   localparam int TABLE_ENTRIES = 16;
   localparam int BANK_SLOTS    = TABLE_ENTRIES / 2;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 1900;

   logic clock;
   logic reset;

   clat_req_if req_if ();
   clat_rsp_if rsp_if ();

   client_address_table_lru #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   // bench copy of the table
   logic [ADDR_W-1:0]  key_tab   [TABLE_ENTRIES];
   logic [STAMP_W-1:0] stamp_tab [TABLE_ENTRIES];
   int unsigned        fill_cnt;

   req_word_type pending_req_q [$];
   rsp_word_type expected_rsp_q [$];

   int    error_count;
   int    cycle_count;
   int    req_gap;
   int    rsp_stall;
   bit    req_calm;
   bit    rsp_calm;

   // random stimulus state
   logic [ADDR_W-1:0]  addr_pool [12];
   logic [ADDR_W-1:0]  pick_addr;
   logic [STAMP_W-1:0] pick_stamp;
   logic [STAMP_W-1:0] wall_clock;
   logic               pick_type;
   int unsigned        sel;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic queue_req(input logic kind, input logic [ADDR_W-1:0] addr,
                            input logic [STAMP_W-1:0] stamp);
      req_word_type w;
      w.req_type    = kind;
      w.client_addr = addr;
      w.now         = stamp;
      pending_req_q.push_back(w);
   endtask

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // applies one request to the bench table and returns the response word
   function automatic rsp_word_type table_apply(input req_word_type w);
      rsp_word_type res;
      int unsigned  base;
      int unsigned  oldest;
      base         = w.client_addr[0] ? BANK_SLOTS : 0;
      res.found        = 1'b0;
      res.evicted_addr = '0;
      if (w.req_type == REQ_LOOKUP) begin
         for (int i = 0; i < BANK_SLOTS; i++) begin
            if (key_tab[base + i] == w.client_addr) res.found = 1'b1;
         end
      end else begin
         oldest = base;
         // strict compare keeps the lowest slot on a tie
         for (int i = 1; i < BANK_SLOTS; i++) begin
            if (stamp_tab[base + i] < stamp_tab[oldest]) oldest = base + i;
         end
         if (fill_cnt < TABLE_ENTRIES) fill_cnt++;
         res.evicted_addr  = key_tab[oldest];
         key_tab[oldest]   = w.client_addr;
         stamp_tab[oldest] = w.now;
      end
      res.occupancy = fill_cnt[OCC_W-1:0];
      return res;
   endfunction

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.word    = '0;
      rsp_if.ready   = 1'b0;
      error_count    = 0;
      cycle_count    = 0;
      req_gap        = 0;
      rsp_stall      = 0;
      req_calm       = 1'b0;
      rsp_calm       = 1'b0;
      fill_cnt       = 0;
      wall_clock     = 32'd100;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         key_tab[i]   = '0;
         stamp_tab[i] = '0;
      end

      // directed words
      queue_req(REQ_LOOKUP, 32'h0000_0000, 32'h0);  // cleared store holds zero
      queue_req(REQ_LOOKUP, 32'h0000_0001, 32'h0);
      queue_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(REQ_INSERT, 32'hFFFF_FFFE, 32'h0);  // all stamps tied
      queue_req(REQ_INSERT, 32'h0000_0002, 32'hFFFF_FFFF);
      queue_req(REQ_INSERT, 32'h0000_0002, 32'hFFFF_FFFF);  // duplicate
      queue_req(REQ_LOOKUP, 32'h0000_0002, 32'h0);
      queue_req(REQ_LOOKUP, 32'hFFFF_FFFE, 32'h0);
      queue_req(REQ_INSERT, 32'hFFFF_FFFF, 32'h8000_0000);
      queue_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      queue_req(REQ_INSERT, 32'h0000_0001, 32'h0000_0001);
      queue_req(REQ_LOOKUP, 32'h0000_0001, 32'hFFFF_FFFF);
      queue_req(REQ_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
      queue_req(REQ_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
      // raise occupancy to one short of saturation
      for (int i = 0; i < 8; i++) queue_req(REQ_INSERT, 32'h100 + 2 * i, 32'd1000 + i);
      queue_req(REQ_LOOKUP, 32'h0000_0000, 32'h0);
      queue_req(REQ_LOOKUP, 32'h0000_0100, 32'h0);

      // random words: mostly a small working set with a running clock
      for (int i = 0; i < 12; i++) addr_pool[i] = $urandom();
      addr_pool[0] = 32'h0;
      addr_pool[1] = 32'hFFFF_FFFF;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 49) == 0) addr_pool[$urandom_range(2, 11)] = $urandom();
         pick_type = ($urandom_range(0, 99) < 55) ? REQ_INSERT : REQ_LOOKUP;
         sel = $urandom_range(0, 99);
         if (sel < 75) pick_addr = addr_pool[$urandom_range(0, 11)];
         else if (sel < 95) pick_addr = $urandom();
         else pick_addr = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFE : 32'h1;
         sel = $urandom_range(0, 99);
         wall_clock = wall_clock + $urandom_range(0, 4);
         if (sel < 80) pick_stamp = wall_clock;
         else if (sel < 90) pick_stamp = $urandom();
         else if (sel < 95) pick_stamp = 32'h0;
         else pick_stamp = 32'hFFFF_FFFF;
         queue_req(pick_type, pick_addr, pick_stamp);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // sampled away from the active edge so the driver's updates have settled
      while (pending_req_q.size() != 0 || req_if.valid || expected_rsp_q.size() != 0)
         @(negedge clock);
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_rsp_q.push_back(table_apply(req_if.word));
         if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
         // a word still waiting for ready is held as it is
         if (!(req_if.valid && !req_if.ready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_req_q.size() != 0) begin
               req_if.word  <= pending_req_q.pop_front();
               req_if.valid <= 1'b1;
               req_gap = pick_gap(req_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("unexpected response word %h", rsp_if.word));
            end else begin
               if (rsp_if.word.found !== expected_rsp_q[0].found)
                  report_mismatch($sformatf("found %b, expected %b",
                     rsp_if.word.found, expected_rsp_q[0].found));
               if (rsp_if.word.evicted_addr !== expected_rsp_q[0].evicted_addr)
                  report_mismatch($sformatf("evicted_addr %h, expected %h",
                     rsp_if.word.evicted_addr, expected_rsp_q[0].evicted_addr));
               if (rsp_if.word.occupancy !== expected_rsp_q[0].occupancy)
                  report_mismatch($sformatf("occupancy %0d, expected %0d",
                     rsp_if.word.occupancy, expected_rsp_q[0].occupancy));
               void'(expected_rsp_q.pop_front());
            end
            rsp_stall = pick_gap(rsp_calm);
         end
         if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
         // stall counts down whether or not a word is waiting
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
